### design/sue_pkg.sv
package sue_pkg;

    // Hash constants
    localparam logic [31:0] HashOffset = 32'h811C_9DC5;
    localparam logic [31:0] HashPrime  = 32'h0100_0193;

    // Length saturates at the smaller of the length limit and the field range
    localparam longint unsigned MaxLength  = 64'd65535;
    localparam logic [15:0]     CountLimit =
        (MaxLength < 64'd65535) ? MaxLength[15:0] : 16'hFFFF;

    // Characters seen by the escape decoder
    localparam logic [7:0] CharBackslash = 8'h5C;
    localparam logic [7:0] CharN         = 8'h6E;
    localparam logic [7:0] CharR         = 8'h72;
    localparam logic [7:0] CharT         = 8'h74;
    localparam logic [7:0] CharDquote    = 8'h22;
    localparam logic [7:0] CharSquote    = 8'h27;
    localparam logic [7:0] CharZero      = 8'h30;
    localparam logic [7:0] CharNewline   = 8'h0A;
    localparam logic [7:0] CharReturn    = 8'h0D;
    localparam logic [7:0] CharTab       = 8'h09;
    localparam logic [7:0] CharNul       = 8'h00;

    // Queue between front and back
    localparam int QDepth = 4;
    localparam int QAddrW = $clog2(QDepth);

    typedef struct packed {
        logic [7:0] in_byte;
        logic       last;
    } sue_in_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic        done_res;
        logic [31:0] hash_value;
        logic [15:0] decoded_length;
    } sue_out_t;

    // One classified input beat: one or two decoded bytes, maybe end of string
    typedef struct packed {
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic       two_bytes;
        logic       fin;
    } sue_entry_t;

    // Queue handshake seen by each side
    typedef struct packed {
        logic full;
        logic empty;
    } sue_qstat_t;

    function automatic logic [31:0] fnv_mix(input logic [31:0] h, input logic [31:0] v);
        logic [31:0] x;
        x = h ^ v;
        return x * HashPrime;
    endfunction

endpackage

### design/string_unescape_and_hash.sv
// String unescape and word hash.
// raw channel (raw_valid/raw_ready/raw_beat): one byte of an escaped string
//   literal per beat, last set on the final byte.
// dec channel (dec_valid/dec_ready/dec_beat): one decoded byte per beat with
//   byte_valid set, then one beat with done_res set carrying the hash and the
//   saturating decoded length; the block is then ready for the next string.
// Path: a decoded byte is written to a queue entry at the edge that takes its
//   raw beat, then loaded into the output register when the back end takes it.
//   Throughput: one decoded byte per cycle in the back end while the output
//   register is free; an unknown escape yields two bytes from one queue entry.
//   At string end the back end folds the 0 to 3 leftover bytes one per cycle
//   through the hash multiplier, then emits the done beat.
// Raw beats are taken at one per cycle while the 4-entry queue has room.
// Reset: asynchronous, active low; hash returns to the offset value, queue
//   and escape state are cleared, no beat is pending.
// Receiver stall: the output register holds its beat, the back end waits,
//   the queue fills and raw_ready drops once it is full.
module string_unescape_and_hash
    import sue_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     raw_valid,
    output logic     raw_ready,
    input  sue_in_t  raw_beat,
    output logic     dec_valid,
    input  logic     dec_ready,
    output sue_out_t dec_beat
);

    sue_qstat_t qstat;
    sue_entry_t push_entry;
    sue_entry_t head_entry;
    logic       push;
    logic       pop;

    // classify raw bytes, track pending escape
    sue_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .raw_valid  (raw_valid),
        .raw_ready  (raw_ready),
        .raw_beat   (raw_beat),
        .qstat      (qstat),
        .push       (push),
        .push_entry (push_entry)
    );

    sue_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head_entry (head_entry),
        .stat       (qstat)
    );

    // emit bytes, hash words, flush tail, emit done beat
    sue_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_entry (head_entry),
        .qstat      (qstat),
        .pop        (pop),
        .dec_valid  (dec_valid),
        .dec_ready  (dec_ready),
        .dec_beat   (dec_beat)
    );

endmodule

### design/sue_queue.sv
module sue_queue
    import sue_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  sue_entry_t push_entry,
    input  logic       pop,
    output sue_entry_t head_entry,
    output sue_qstat_t stat
);

    sue_entry_t          mem_reg [QDepth];
    logic [QAddrW-1:0]   wr_ptr_reg;
    logic [QAddrW-1:0]   rd_ptr_reg;
    logic [QAddrW:0]     count_reg;
    logic [QAddrW:0]     count_next;
    logic                do_push;
    logic                do_pop;

    assign stat.full  = (count_reg == (QAddrW+1)'(QDepth));
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign head_entry = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

### design/sue_front.sv
module sue_front
    import sue_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       raw_valid,
    output logic       raw_ready,
    input  sue_in_t    raw_beat,
    input  sue_qstat_t qstat,
    output logic       push,
    output sue_entry_t push_entry
);

    logic       escape_pending_reg;
    logic       escape_pending_next;
    logic       accept;
    logic [7:0] mapped;
    logic       known;

    assign raw_ready = !qstat.full;
    assign accept    = raw_valid && raw_ready;

    // Second byte of an escape sequence
    always_comb
    begin
        known  = 1'b1;
        mapped = raw_beat.in_byte;
        case (raw_beat.in_byte)
            CharN:         mapped = CharNewline;
            CharR:         mapped = CharReturn;
            CharT:         mapped = CharTab;
            CharDquote:    mapped = CharDquote;
            CharSquote:    mapped = CharSquote;
            CharBackslash: mapped = CharBackslash;
            CharZero:      mapped = CharNul;
            default:       known  = 1'b0;
        endcase
    end

    always_comb
    begin
        escape_pending_next  = escape_pending_reg;
        push                 = 1'b0;
        push_entry.byte0     = raw_beat.in_byte;
        push_entry.byte1     = raw_beat.in_byte;
        push_entry.two_bytes = 1'b0;
        push_entry.fin       = raw_beat.last;
        if (accept)
        begin
            if (escape_pending_reg)
            begin
                escape_pending_next = 1'b0;
                push                = 1'b1;
                if (known)
                begin
                    push_entry.byte0 = mapped;
                end
                else
                begin
                    // unknown escape keeps the backslash too
                    push_entry.byte0     = CharBackslash;
                    push_entry.two_bytes = 1'b1;
                end
            end
            else if ((raw_beat.in_byte == CharBackslash) && !raw_beat.last)
            begin
                escape_pending_next = 1'b1;
            end
            else
            begin
                push = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            escape_pending_reg <= 1'b0;
        end
        else
        begin
            escape_pending_reg <= escape_pending_next;
        end
    end

endmodule

### design/sue_back.sv
module sue_back
    import sue_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  sue_entry_t head_entry,
    input  sue_qstat_t qstat,
    output logic       pop,
    output logic       dec_valid,
    input  logic       dec_ready,
    output sue_out_t   dec_beat
);

    typedef enum logic [2:0] {
        BK_BYTE  = 3'b001,
        BK_FLUSH = 3'b010,
        BK_DONE  = 3'b100
    } back_state_t;

    back_state_t state_reg, state_next;
    logic [31:0] hash_reg, hash_next;
    logic [23:0] wbuf_reg, wbuf_next;
    logic [1:0]  fill_reg, fill_next;
    logic [15:0] count_reg, count_next;
    logic        sel_reg, sel_next;
    logic [1:0]  flush_idx_reg, flush_idx_next;
    logic        out_valid_reg, out_valid_next;
    sue_out_t    out_reg, out_next;
    logic        out_free;
    logic [7:0]  cur_byte;
    logic [7:0]  tail_byte;

    assign out_free  = !out_valid_reg || dec_ready;
    assign dec_valid = out_valid_reg;
    assign dec_beat  = out_reg;
    assign cur_byte  = sel_reg ? head_entry.byte1 : head_entry.byte0;

    always_comb
    begin
        case (flush_idx_reg)
            2'd0:    tail_byte = wbuf_reg[7:0];
            2'd1:    tail_byte = wbuf_reg[15:8];
            default: tail_byte = wbuf_reg[23:16];
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        hash_next      = hash_reg;
        wbuf_next      = wbuf_reg;
        fill_next      = fill_reg;
        count_next     = count_reg;
        sel_next       = sel_reg;
        flush_idx_next = flush_idx_reg;
        out_valid_next = out_valid_reg && !dec_ready;
        out_next       = out_reg;
        pop            = 1'b0;

        case (state_reg)
            BK_BYTE:
            begin
                if (!qstat.empty && out_free)
                begin
                    out_valid_next          = 1'b1;
                    out_next.out_byte       = cur_byte;
                    out_next.byte_valid     = 1'b1;
                    out_next.done_res       = 1'b0;
                    out_next.hash_value     = '0;
                    out_next.decoded_length = '0;
                    if (count_reg != CountLimit)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                    if (fill_reg == 2'd3)
                    begin
                        hash_next = fnv_mix(hash_reg, {cur_byte, wbuf_reg});
                        wbuf_next = '0;
                        fill_next = '0;
                    end
                    else
                    begin
                        case (fill_reg)
                            2'd0:    wbuf_next[7:0]   = cur_byte;
                            2'd1:    wbuf_next[15:8]  = cur_byte;
                            default: wbuf_next[23:16] = cur_byte;
                        endcase
                        fill_next = fill_reg + 1'b1;
                    end
                    if (head_entry.two_bytes && !sel_reg)
                    begin
                        sel_next = 1'b1;
                    end
                    else
                    begin
                        pop      = 1'b1;
                        sel_next = 1'b0;
                        if (head_entry.fin)
                        begin
                            flush_idx_next = '0;
                            state_next     = BK_FLUSH;
                        end
                    end
                end
            end
            BK_FLUSH:
            begin
                // fold leftover bytes one per cycle
                if (flush_idx_reg < fill_reg)
                begin
                    hash_next      = fnv_mix(hash_reg, {24'd0, tail_byte});
                    flush_idx_next = flush_idx_reg + 1'b1;
                end
                else
                begin
                    state_next = BK_DONE;
                end
            end
            BK_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next          = 1'b1;
                    out_next.out_byte       = '0;
                    out_next.byte_valid     = 1'b0;
                    out_next.done_res       = 1'b1;
                    out_next.hash_value     = hash_reg;
                    out_next.decoded_length = count_reg;
                    hash_next               = HashOffset;
                    wbuf_next               = '0;
                    fill_next               = '0;
                    count_next              = '0;
                    state_next              = BK_BYTE;
                end
            end
            default:
            begin
                state_next = BK_BYTE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_BYTE;
            hash_reg      <= HashOffset;
            wbuf_reg      <= '0;
            fill_reg      <= '0;
            count_reg     <= '0;
            sel_reg       <= 1'b0;
            flush_idx_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            hash_reg      <= hash_next;
            wbuf_reg      <= wbuf_next;
            fill_reg      <= fill_next;
            count_reg     <= count_next;
            sel_reg       <= sel_next;
            flush_idx_reg <= flush_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
